[rtl/bpa_pkg.sv]
// Package for the buddy page allocator: geometry constants, status and
// operation codes, and the controller state type. No dependencies.
package bpa_pkg;

  localparam int PAGE_W       = 8;
  localparam int NPAGES       = 1 << PAGE_W;
  localparam int NLEV         = PAGE_W + 1;
  localparam int LEV_W        = 4;
  localparam int TOP_LEV      = NLEV - 1;
  localparam int SIZE_W       = 24;
  localparam int PAGE_SHIFT_D = 12;
  localparam int LANES        = 8;
  localparam int LANE_W       = 3;
  localparam int OB_ROWS      = NPAGES / LANES;
  localparam int OB_ROW_AW    = PAGE_W - LANE_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOBLK    = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_FIND,
    S_A_CLR,
    S_A_SET2,
    S_SWEEP,
    S_F_ORD,
    S_F_LEV,
    S_F_CHK,
    S_F_SETI,
    S_FIN
  } state_t;

endpackage

[rtl/buddy_page_allocator.sv]
// Binary buddy allocator over 256 pages, top level.
// Depends on bpa_pkg; holds the free map and block order memories.
//
// One item is taken at a time. The free map is a 9-row by 256-bit memory
// (one row per block order) and the block order table is a 32-row memory of
// eight 4-bit lanes; both have a registered read and are updated by
// read-modify-write. An allocate takes the lowest free block of the level
// found; each split level sets both halves one level down and then sweeps
// the 8-page rows of the block whose order entries are rewritten. A free
// reads the block's order, then checks its buddy; each merge clears the
// buddy and sweeps the merged block. Oversize and no-block requests go
// straight to the finish state. Runs of order entries are the dominant
// cost: a split or merge of a block of 2^L pages walks 2^L/8 rows, at least
// one. No clearing pass is needed after reset: per-row valid bits make
// untouched rows read as their reset contents. A result is held in an output
// register; the next item is accepted once the previous one has moved there.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_SHIFT = PAGE_SHIFT_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [PAGE_W-1:0] in_free_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [PAGE_W-1:0] out_page
);

  // Wide enough for the full request and the largest block size.
  localparam int SZC_W = (PAGE_SHIFT + NLEV > SIZE_W) ? PAGE_SHIFT + NLEV : SIZE_W;

  state_t state_r, state_nxt;

  logic              op_r, op_nxt;
  logic [LEV_W-1:0]  lev_r, lev_nxt;
  logic [LEV_W-1:0]  req_r, req_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt;
  logic [PAGE_W-1:0] fp_r, fp_nxt;
  logic [PAGE_W-1:0] p_r, p_nxt;
  logic [PAGE_W-1:0] bud_r, bud_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [PAGE_W-1:0] res_pg_r, res_pg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [NLEV-1:0]   nonempty_r, nonempty_nxt;

  // Free map memory: one row per level.
  logic [NPAGES-1:0] fm_mem [NLEV];
  logic [NLEV-1:0]   fm_vld_r;
  logic [NPAGES-1:0] fm_rd_r;
  logic              fm_rd_vld_r;
  logic [LEV_W-1:0]  fm_ra_r;
  logic              fm_re, fm_we;
  logic [LEV_W-1:0]  fm_ra, fm_wa;
  logic [NPAGES-1:0] fm_wd;
  logic [NPAGES-1:0] row_eff;

  // Block order memory: eight lanes per row.
  logic [LANES*LEV_W-1:0] ob_mem [OB_ROWS];
  logic [OB_ROWS-1:0]     ob_vld_r;
  logic [LANES*LEV_W-1:0] ob_rd_r;
  logic                   ob_rd_vld_r;
  logic                   ob_re;
  logic [LANES-1:0]       ob_lane_we;
  logic [LEV_W-1:0]       ob_lane_wd [LANES];

  // Order run sweep.
  logic [PAGE_W-1:0]    sw_a_r, sw_a_nxt, sw_b_r, sw_b_nxt;
  logic [PAGE_W:0]      sw_len_r, sw_len_nxt;
  logic [LEV_W-1:0]     sw_val_r, sw_val_nxt;
  logic [OB_ROW_AW-1:0] sw_row_r, sw_row_nxt, sw_end_r, sw_end_nxt;

  logic              sw_go;
  logic [PAGE_W-1:0] sg_a, sg_b;
  logic [PAGE_W:0]   sg_len;
  logic [LEV_W-1:0]  sg_val;
  logic [PAGE_W-1:0] sg_lo, sg_hi_st;
  logic [PAGE_W:0]   sg_hi;

  logic [LEV_W-1:0]  req_lev, avail_lev, ob_lev;
  logic              req_ok, avail_ok;
  logic [PAGE_W-1:0] first_p;
  logic [PAGE_W:0]   half_dn, half_up;

  // Size to level: smallest level whose block covers the request.
  always_comb begin
    req_lev = '0;
    req_ok  = 1'b0;
    for (int i = NLEV - 1; i >= 0; i--) begin
      if ((SZC_W'(1) << (i + PAGE_SHIFT)) >= SZC_W'(in_req_size)) begin
        req_lev = LEV_W'(i);
        req_ok  = 1'b1;
      end
    end
  end

  // Lowest non-empty level at or above the request.
  always_comb begin
    avail_lev = '0;
    avail_ok  = 1'b0;
    for (int i = NLEV - 1; i >= 0; i--) begin
      if (nonempty_r[i] && (LEV_W'(i) >= req_lev)) begin
        avail_lev = LEV_W'(i);
        avail_ok  = 1'b1;
      end
    end
  end

  assign row_eff = fm_rd_vld_r ? fm_rd_r :
                   ((fm_ra_r == LEV_W'(TOP_LEV)) ? NPAGES'(1) : '0);

  // Lowest set bit of the row just read.
  always_comb begin
    first_p = '0;
    for (int i = NPAGES - 1; i >= 0; i--) begin
      if (row_eff[i]) first_p = PAGE_W'(i);
    end
  end

  assign ob_lev  = ob_rd_vld_r ? ob_rd_r[idx_r[LANE_W-1:0]*LEV_W +: LEV_W]
                               : LEV_W'(TOP_LEV);
  assign half_dn = (PAGE_W+1)'(1) << (lev_r - LEV_W'(1));
  assign half_up = (PAGE_W+1)'(1) << lev_r;

  // Sweep range: rows covering both runs, clipped at the last page.
  assign sg_lo    = (sg_a < sg_b) ? sg_a : sg_b;
  assign sg_hi_st = (sg_a < sg_b) ? sg_b : sg_a;
  assign sg_hi    = {1'b0, sg_hi_st} + sg_len - (PAGE_W+1)'(1);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    lev_nxt        = lev_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    fp_nxt         = fp_r;
    p_nxt          = p_r;
    bud_nxt        = bud_r;
    res_st_nxt     = res_st_r;
    res_pg_nxt     = res_pg_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    sw_row_nxt     = sw_row_r;
    fm_re          = 1'b0;
    fm_ra          = lev_r;
    fm_we          = 1'b0;
    fm_wa          = lev_r;
    fm_wd          = row_eff;
    ob_re          = 1'b0;
    sw_go          = 1'b0;
    sg_a           = p_r;
    sg_b           = bud_r;
    sg_len         = half_dn;
    sg_val         = lev_r - LEV_W'(1);
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_op;
          idx_nxt = in_free_page;
          fp_nxt  = in_free_page;
          if (in_op == OP_FREE) begin
            state_nxt = S_F_ORD;
          end else if (!req_ok) begin
            res_st_nxt = ST_OVERSIZE;
            res_pg_nxt = '0;
            state_nxt  = S_FIN;
          end else if (!avail_ok) begin
            res_st_nxt = ST_NOBLK;
            res_pg_nxt = '0;
            state_nxt  = S_FIN;
          end else begin
            req_nxt   = req_lev;
            lev_nxt   = avail_lev;
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        fm_re     = 1'b1;
        state_nxt = S_A_FIND;
      end
      S_A_FIND: begin
        p_nxt     = first_p;
        state_nxt = S_A_CLR;
      end
      S_A_CLR: begin
        fm_we = 1'b1;
        fm_wd = row_eff & ~(NPAGES'(1) << p_r);
        if (lev_r == req_r) begin
          res_st_nxt = ST_OK;
          res_pg_nxt = p_r;
          state_nxt  = S_FIN;
        end else begin
          bud_nxt   = p_r ^ half_dn[PAGE_W-1:0];
          fm_re     = 1'b1;
          fm_ra     = lev_r - LEV_W'(1);
          state_nxt = S_A_SET2;
        end
      end
      S_A_SET2: begin
        fm_we     = 1'b1;
        fm_wa     = lev_r - LEV_W'(1);
        fm_wd     = row_eff | (NPAGES'(1) << p_r) | (NPAGES'(1) << bud_r);
        sw_go     = 1'b1;
        lev_nxt   = lev_r - LEV_W'(1);
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (sw_row_r == sw_end_r) begin
          state_nxt = (op_r == OP_ALLOC) ? S_A_RD : S_F_ORD;
        end else begin
          sw_row_nxt = sw_row_r + OB_ROW_AW'(1);
        end
      end
      S_F_ORD: begin
        ob_re     = 1'b1;
        state_nxt = S_F_LEV;
      end
      S_F_LEV: begin
        if (ob_lev >= LEV_W'(TOP_LEV)) begin
          // Whole-memory block comes back only into an empty map.
          if (nonempty_r == '0) begin
            lev_nxt   = LEV_W'(TOP_LEV);
            fm_re     = 1'b1;
            fm_ra     = LEV_W'(TOP_LEV);
            state_nxt = S_F_SETI;
          end else begin
            res_st_nxt = ST_OK;
            res_pg_nxt = fp_r;
            state_nxt  = S_FIN;
          end
        end else begin
          lev_nxt   = ob_lev;
          bud_nxt   = idx_r ^ ((PAGE_W)'(1) << ob_lev);
          fm_re     = 1'b1;
          fm_ra     = ob_lev;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        fm_we = 1'b1;
        if (row_eff[bud_r]) begin
          // Buddy free: merge and climb one level.
          fm_wd     = row_eff & ~(NPAGES'(1) << bud_r);
          sw_go     = 1'b1;
          sg_a      = idx_r;
          sg_len    = half_up;
          sg_val    = lev_r + LEV_W'(1);
          idx_nxt   = (bud_r < idx_r) ? bud_r : idx_r;
          state_nxt = S_SWEEP;
        end else begin
          fm_wd      = row_eff | (NPAGES'(1) << idx_r);
          res_st_nxt = ST_OK;
          res_pg_nxt = fp_r;
          state_nxt  = S_FIN;
        end
      end
      S_F_SETI: begin
        fm_we      = 1'b1;
        fm_wd      = row_eff | (NPAGES'(1) << idx_r);
        res_st_nxt = ST_OK;
        res_pg_nxt = fp_r;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_page_nxt   = res_pg_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (sw_go) begin
      sw_row_nxt = sg_lo[PAGE_W-1:LANE_W];
      sw_end_nxt = sg_hi[PAGE_W] ? '1 : sg_hi[PAGE_W-1:LANE_W];
      sw_a_nxt   = sg_a;
      sw_b_nxt   = sg_b;
      sw_len_nxt = sg_len;
      sw_val_nxt = sg_val;
    end else begin
      sw_end_nxt = sw_end_r;
      sw_a_nxt   = sw_a_r;
      sw_b_nxt   = sw_b_r;
      sw_len_nxt = sw_len_r;
      sw_val_nxt = sw_val_r;
    end

    nonempty_nxt = nonempty_r;
    if (fm_we) nonempty_nxt[fm_wa] = |fm_wd;
  end

  // Lane enables for the current sweep row; a row never written fills its
  // other lanes with the reset order.
  always_comb begin
    logic [PAGE_W-1:0] pg;
    logic              in_a, in_b;
    for (int k = 0; k < LANES; k++) begin
      pg   = {sw_row_r, LANE_W'(k)};
      in_a = (pg >= sw_a_r) && ({1'b0, pg} < ({1'b0, sw_a_r} + sw_len_r));
      in_b = (pg >= sw_b_r) && ({1'b0, pg} < ({1'b0, sw_b_r} + sw_len_r));
      ob_lane_we[k] = (state_r == S_SWEEP) && (in_a || in_b || !ob_vld_r[sw_row_r]);
      ob_lane_wd[k] = (in_a || in_b) ? sw_val_r : LEV_W'(TOP_LEV);
    end
  end

  always_ff @(posedge clk) begin
    if (fm_re) begin
      fm_rd_r     <= fm_mem[fm_ra];
      fm_rd_vld_r <= fm_vld_r[fm_ra];
      fm_ra_r     <= fm_ra;
    end
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    if (ob_re) begin
      ob_rd_r     <= ob_mem[idx_r[PAGE_W-1:LANE_W]];
      ob_rd_vld_r <= ob_vld_r[idx_r[PAGE_W-1:LANE_W]];
    end
    for (int k = 0; k < LANES; k++) begin
      if (ob_lane_we[k]) ob_mem[sw_row_r][k*LEV_W +: LEV_W] <= ob_lane_wd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nonempty_r  <= NLEV'(1) << TOP_LEV;
      fm_vld_r    <= '0;
      ob_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nonempty_r  <= nonempty_nxt;
      if (fm_we) fm_vld_r[fm_wa] <= 1'b1;
      if (state_r == S_SWEEP) ob_vld_r[sw_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lev_r        <= lev_nxt;
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    fp_r         <= fp_nxt;
    p_r          <= p_nxt;
    bud_r        <= bud_nxt;
    res_st_r     <= res_st_nxt;
    res_pg_r     <= res_pg_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    sw_row_r     <= sw_row_nxt;
    sw_end_r     <= sw_end_nxt;
    sw_a_r       <= sw_a_nxt;
    sw_b_r       <= sw_b_nxt;
    sw_len_r     <= sw_len_nxt;
    sw_val_r     <= sw_val_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_page   = out_page_r;

  // Split walk never goes below the requested level.
  a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_RD) |-> (lev_r >= req_r) && (lev_r <= LEV_W'(TOP_LEV)))
    else $error("split level out of range");

  // Sweep stays inside its row range.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (sw_row_r <= sw_end_r))
    else $error("sweep row past end");

  // A new result only comes out of the finish state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result without finish");

  // An accepted item keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted item while busy");

endmodule
